// ===== rtl/core/lavm_pkg.sv =====
// shared types, constants and arithmetic helpers of the look-at view matrix core
package lavm_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned DIFF_W = 33;
	localparam int unsigned AXIS_W = 18;

	localparam logic [1:0] ROW_X = 2'd0;
	localparam logic [1:0] ROW_Y = 2'd1;
	localparam logic [1:0] ROW_Z = 2'd2;

	localparam logic signed [AXIS_W-1:0] AXIS_ONE = 18'sd65536;

	// one camera setup as it travels from the front to the back
	typedef struct packed {
		logic [2:0][WORD_W-1:0] cam;
		logic [2:0][WORD_W-1:0] up;
		logic [2:0][DIFF_W-1:0] d;
		logic                   zero;
	} job_t;

	// negate, round half away from zero from Q32.32 to Q16.16, saturate
	function automatic logic signed [WORD_W-1:0] trans_round(input logic signed [63:0] s);
		logic signed [63:0] t;
		logic [63:0]        mag;
		logic signed [63:0] r;
		t   = -s;
		mag = t[63] ? 64'(-t) : 64'(t);
		mag = (mag + 64'd32768) >> 16;
		r   = t[63] ? -$signed(mag) : $signed(mag);
		if (r > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (r < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return r[WORD_W-1:0];
	endfunction

endpackage

// ===== rtl/core/look_at_view_matrix_core.sv =====
// look-at view matrix core: emits right, up and back rows per camera setup
// the first row follows three normalizations: scaling steps, a bit-serial square root and
// a radix-2 divider each; an axis that collapses skips its normalization
// one setup at a time in the back end; rows one per cycle while out_stall is low
// on-target camera: translations only; a two-entry queue takes setups while the back end works
// reset: asynchronous active low, clears queue, sequencer and output valid
module look_at_view_matrix_core import lavm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [WORD_W-1:0]        cam_x,
	input  logic [WORD_W-1:0]        cam_y,
	input  logic [WORD_W-1:0]        cam_z,
	input  logic [WORD_W-1:0]        target_x,
	input  logic [WORD_W-1:0]        target_y,
	input  logic [WORD_W-1:0]        target_z,
	input  logic [WORD_W-1:0]        upvec_x,
	input  logic [WORD_W-1:0]        upvec_y,
	input  logic [WORD_W-1:0]        upvec_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               row_index,
	output logic signed [AXIS_W-1:0] axis_a,
	output logic signed [AXIS_W-1:0] axis_b,
	output logic signed [AXIS_W-1:0] axis_c,
	output logic signed [WORD_W-1:0] shift,
	output logic                     degenerate,
	output logic                     last_row
);

	job_t front_job;
	job_t back_job;
	logic q_full;
	logic q_nonempty;
	logic q_pop;

	lavm_front u_front (
		.cam_x    (cam_x),
		.cam_y    (cam_y),
		.cam_z    (cam_z),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.upvec_x  (upvec_x),
		.upvec_y  (upvec_y),
		.upvec_z  (upvec_z),
		.job      (front_job)
	);

	lavm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (in_valid && !q_full),
		.push_job (front_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.pop_job  (back_job)
	);

	lavm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (q_nonempty),
		.job        (back_job),
		.job_pop    (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.axis_a     (axis_a),
		.axis_b     (axis_b),
		.axis_c     (axis_c),
		.shift      (shift),
		.degenerate (degenerate),
		.last_row   (last_row)
	);

	assign in_stall = q_full;

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> axis_a == '0 && axis_b == '0 && axis_c == '0
			&& shift == '0)
		else $error("degenerate row carries nonzero values");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> axis_a <= AXIS_ONE && axis_a >= -AXIS_ONE
			&& axis_b <= AXIS_ONE && axis_b >= -AXIS_ONE
			&& axis_c <= AXIS_ONE && axis_c >= -AXIS_ONE)
		else $error("axis component beyond unit length");

	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && row_index != ROW_Z |=> out_valid
			&& row_index == $past(row_index) + 2'd1)
		else $error("rows of one transaction not back to back in order");

endmodule

// ===== rtl/core/lavm_front.sv =====
// front end: accepts a camera setup, forms the back vector and flags a zero one
module lavm_front import lavm_pkg::*; (
	input  logic [WORD_W-1:0] cam_x,
	input  logic [WORD_W-1:0] cam_y,
	input  logic [WORD_W-1:0] cam_z,
	input  logic [WORD_W-1:0] target_x,
	input  logic [WORD_W-1:0] target_y,
	input  logic [WORD_W-1:0] target_z,
	input  logic [WORD_W-1:0] upvec_x,
	input  logic [WORD_W-1:0] upvec_y,
	input  logic [WORD_W-1:0] upvec_z,
	output job_t              job
);

	logic [2:0][WORD_W-1:0] cam;
	logic [2:0][WORD_W-1:0] tgt;

	assign cam = {cam_z, cam_y, cam_x};
	assign tgt = {target_z, target_y, target_x};

	always_comb begin
		job.cam = cam;
		job.up  = {upvec_z, upvec_y, upvec_x};
		for (int i = 0; i < 3; i++) begin
			job.d[i] = DIFF_W'($signed({cam[i][WORD_W-1], cam[i]})
				- $signed({tgt[i][WORD_W-1], tgt[i]}));
		end
		// camera on the target: every axis collapses
		job.zero = (cam == tgt);
	end

endmodule

// ===== rtl/core/lavm_queue.sv =====
// two-entry queue between the front end and the back end
module lavm_queue import lavm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output job_t pop_job
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign nonempty = (cnt_q != 2'd0);
	assign pop_job  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

endmodule

// ===== rtl/core/lavm_back.sv =====
// back end: normalization, cross products, translations and the row output register
module lavm_back import lavm_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     job_valid,
	input  job_t                     job,
	output logic                     job_pop,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               row_index,
	output logic signed [AXIS_W-1:0] axis_a,
	output logic signed [AXIS_W-1:0] axis_b,
	output logic signed [AXIS_W-1:0] axis_c,
	output logic signed [WORD_W-1:0] shift,
	output logic                     degenerate,
	output logic                     last_row
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_ABS   = 4'd1;
	localparam logic [3:0] S_SCALE = 4'd2;
	localparam logic [3:0] S_SQ    = 4'd3;
	localparam logic [3:0] S_SQRT  = 4'd4;
	localparam logic [3:0] S_DIVI  = 4'd5;
	localparam logic [3:0] S_DIV   = 4'd6;
	localparam logic [3:0] S_SIGN  = 4'd7;
	localparam logic [3:0] S_NEXT  = 4'd8;
	localparam logic [3:0] S_CROSS = 4'd9;
	localparam logic [3:0] S_TRANS = 4'd10;
	localparam logic [3:0] S_ROUND = 4'd11;
	localparam logic [3:0] S_EMIT  = 4'd12;

	logic [3:0] state_q;
	logic [1:0] cur_q;
	logic [2:0] k_q;
	logic [4:0] j_q;
	logic       out_valid_q;

	logic signed [WORD_W-1:0] cam_q [3];
	logic signed [WORD_W-1:0] up_q [3];
	logic signed [63:0]       vec_q [3];
	logic [63:0]              mg_q [3];
	logic [63:0]              m_q;
	logic signed [63:0]       prod_q;
	logic [63:0]              acc_q;
	logic [63:0]              n_q;
	logic [63:0]              res_q;
	logic [30:0]              len_q;
	logic [31:0]              rem_q [3];
	logic [17:0]              nlo_q [3];
	logic [17:0]              quo_q [3];
	logic [2:0][2:0][AXIS_W-1:0] ax_q;
	logic [2:0]               deg_q;
	logic signed [63:0]       tsum_q [3];
	logic signed [WORD_W-1:0] tr_q [3];

	logic [1:0]               row_q;
	logic signed [AXIS_W-1:0] oa_q, ob_q, oc_q;
	logic signed [WORD_W-1:0] osh_q;
	logic                     odeg_q;

	logic [63:0]              mg_c [3];
	logic [63:0]              m_c;
	logic signed [WORD_W-1:0] mul_a, mul_b;
	logic [1:0]               ai, bi;
	logic [63:0]              bitv, sq_t;
	logic                     out_free;
	logic                     m_ok;

	function automatic logic signed [WORD_W-1:0] sx_axis(input logic [AXIS_W-1:0] v);
		return {{(WORD_W-AXIS_W){v[AXIS_W-1]}}, v};
	endfunction

	assign out_free = !out_valid_q || !out_stall;
	assign job_pop  = (state_q == S_IDLE) && job_valid;
	assign m_ok     = (m_q >= 64'h2000_0000) && (m_q < 64'h4000_0000);

	always_comb begin
		m_c = 64'd0;
		for (int i = 0; i < 3; i++) begin
			mg_c[i] = vec_q[i][63] ? 64'(-vec_q[i]) : 64'(vec_q[i]);
			if (mg_c[i] > m_c) m_c = mg_c[i];
		end
	end

	// cross product term order: a1b2 a2b1 a2b0 a0b2 a0b1 a1b0
	always_comb begin
		unique case (k_q)
			3'd0: begin ai = 2'd1; bi = 2'd2; end
			3'd1: begin ai = 2'd2; bi = 2'd1; end
			3'd2: begin ai = 2'd2; bi = 2'd0; end
			3'd3: begin ai = 2'd0; bi = 2'd2; end
			3'd4: begin ai = 2'd0; bi = 2'd1; end
			3'd5: begin ai = 2'd1; bi = 2'd0; end
			default: begin ai = 2'd0; bi = 2'd0; end
		endcase
	end

	// one shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SQ: begin
				if (k_q < 3'd3) begin
					mul_a = $signed(mg_q[k_q[1:0]][WORD_W-1:0]);
					mul_b = $signed(mg_q[k_q[1:0]][WORD_W-1:0]);
				end
			end
			S_CROSS: begin
				if (cur_q == ROW_X) begin
					mul_a = up_q[ai];
					mul_b = sx_axis(ax_q[ROW_Z][bi]);
				end else begin
					mul_a = sx_axis(ax_q[ROW_Z][ai]);
					mul_b = sx_axis(ax_q[ROW_X][bi]);
				end
			end
			S_TRANS: begin
				if (k_q < 3'd3) begin
					mul_a = sx_axis(ax_q[cur_q][k_q[1:0]]);
					mul_b = cam_q[k_q[1:0]];
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign bitv = 64'd1 << {j_q, 1'b0};
	assign sq_t = res_q + bitv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= ROW_X;
			k_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						k_q <= '0;
						if (job.zero) begin
							cur_q   <= ROW_X;
							state_q <= S_TRANS;
						end else begin
							cur_q   <= ROW_Z;
							state_q <= S_ABS;
						end
					end
				end
				S_ABS: state_q <= (m_c == 64'd0) ? S_NEXT : S_SCALE;
				S_SCALE: begin
					if (m_ok) begin
						k_q     <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd3) begin
						j_q     <= 5'd31;
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					j_q <= j_q - 5'd1;
					if (j_q == 5'd0) state_q <= S_DIVI;
				end
				S_DIVI: begin
					j_q     <= 5'd17;
					state_q <= S_DIV;
				end
				S_DIV: begin
					j_q <= j_q - 5'd1;
					if (j_q == 5'd0) state_q <= S_SIGN;
				end
				S_SIGN: state_q <= S_NEXT;
				S_NEXT: begin
					k_q <= '0;
					priority if (cur_q == ROW_Z) begin
						cur_q   <= ROW_X;
						state_q <= S_CROSS;
					end else if (cur_q == ROW_X) begin
						cur_q   <= ROW_Y;
						state_q <= S_CROSS;
					end else begin
						cur_q   <= ROW_X;
						state_q <= S_TRANS;
					end
				end
				S_CROSS: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd6) state_q <= S_ABS;
				end
				S_TRANS: begin
					if (k_q == 3'd3) begin
						k_q <= '0;
						if (cur_q == ROW_Z) begin
							cur_q   <= ROW_X;
							state_q <= S_ROUND;
						end else begin
							cur_q <= cur_q + 2'd1;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_ROUND: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (cur_q == ROW_Z) begin
							cur_q   <= ROW_X;
							state_q <= S_IDLE;
						end else begin
							cur_q <= cur_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			S_IDLE: begin
				if (job_valid) begin
					for (int i = 0; i < 3; i++) begin
						cam_q[i] <= $signed(job.cam[i]);
						up_q[i]  <= $signed(job.up[i]);
						vec_q[i] <= 64'($signed(job.d[i]));
					end
					if (job.zero) begin
						ax_q  <= '0;
						deg_q <= 3'b111;
					end
				end
			end
			S_ABS: begin
				for (int i = 0; i < 3; i++) mg_q[i] <= mg_c[i];
				m_q <= m_c;
				if (m_c == 64'd0) begin
					ax_q[cur_q]  <= '0;
					deg_q[cur_q] <= 1'b1;
				end
			end
			S_SCALE: begin
				// coarse then fine steps until the largest magnitude sits in [2^29, 2^30)
				priority if (m_q >= 64'h40_0000_0000) begin
					m_q <= m_q >> 8;
					for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] >> 8;
				end else if (m_q >= 64'h4000_0000) begin
					m_q <= m_q >> 1;
					for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] >> 1;
				end else if (m_q < 64'h20_0000) begin
					m_q <= m_q << 8;
					for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] << 8;
				end else if (m_q < 64'h2000_0000) begin
					m_q <= m_q << 1;
					for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] << 1;
				end else begin
					m_q <= m_q;
				end
			end
			S_SQ: begin
				if (k_q == 3'd0) acc_q <= 64'd0;
				else acc_q <= acc_q + 64'(prod_q);
				if (k_q == 3'd3) begin
					n_q   <= acc_q + 64'(prod_q);
					res_q <= 64'd0;
				end
			end
			S_SQRT: begin
				if (n_q >= sq_t) begin
					n_q   <= n_q - sq_t;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			S_DIVI: begin
				len_q <= res_q[30:0];
				for (int i = 0; i < 3; i++) begin
					logic [46:0] num;
					num      = {1'b0, mg_q[i][29:0], 16'h0000} + 47'(res_q[30:1]);
					rem_q[i] <= 32'(num[46:18]);
					nlo_q[i] <= num[17:0];
					quo_q[i] <= '0;
				end
			end
			S_DIV: begin
				for (int i = 0; i < 3; i++) begin
					logic [31:0] r2;
					r2 = {rem_q[i][30:0], nlo_q[i][17]};
					nlo_q[i] <= {nlo_q[i][16:0], 1'b0};
					if (r2 >= {1'b0, len_q}) begin
						rem_q[i] <= r2 - {1'b0, len_q};
						quo_q[i] <= {quo_q[i][16:0], 1'b1};
					end else begin
						rem_q[i] <= r2;
						quo_q[i] <= {quo_q[i][16:0], 1'b0};
					end
				end
			end
			S_SIGN: begin
				for (int i = 0; i < 3; i++) begin
					ax_q[cur_q][i] <= vec_q[i][63] ? 18'(-quo_q[i]) : quo_q[i];
				end
				deg_q[cur_q] <= 1'b0;
			end
			S_CROSS: begin
				unique case (k_q)
					3'd0: for (int i = 0; i < 3; i++) vec_q[i] <= 64'sd0;
					3'd1: vec_q[0] <= vec_q[0] + prod_q;
					3'd2: vec_q[0] <= vec_q[0] - prod_q;
					3'd3: vec_q[1] <= vec_q[1] + prod_q;
					3'd4: vec_q[1] <= vec_q[1] - prod_q;
					3'd5: vec_q[2] <= vec_q[2] + prod_q;
					3'd6: vec_q[2] <= vec_q[2] - prod_q;
					default: vec_q[0] <= vec_q[0];
				endcase
			end
			S_TRANS: begin
				if (k_q == 3'd0) tsum_q[cur_q] <= 64'sd0;
				else tsum_q[cur_q] <= tsum_q[cur_q] + prod_q;
			end
			S_ROUND: begin
				for (int i = 0; i < 3; i++) tr_q[i] <= trans_round(tsum_q[i]);
			end
			S_EMIT: begin
				if (out_free) begin
					row_q  <= cur_q;
					oa_q   <= ax_q[cur_q][0];
					ob_q   <= ax_q[cur_q][1];
					oc_q   <= ax_q[cur_q][2];
					osh_q  <= tr_q[cur_q];
					odeg_q <= deg_q[cur_q];
				end
			end
			default: m_q <= m_q;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign row_index  = row_q;
	assign axis_a     = oa_q;
	assign axis_b     = ob_q;
	assign axis_c     = oc_q;
	assign shift      = osh_q;
	assign degenerate = odeg_q;
	assign last_row   = (row_q == ROW_Z);

endmodule
